// ===== design/assert_macros.svh =====
// Assertion macros shared by the edge core RTL.
// Clocked, reset-gated concurrent checks that report through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge while reset is released.
`define SOB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check with reset active high gating it directly.
`define SOB_ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ===== design/sob_pkg.sv =====
// Shared types and constants for the Sobel gray edge core.
// No dependencies; used by the lane, merge and top modules.
package sob_pkg;

  localparam int PIX_W    = 30;  // packed pixel field width
  localparam int WIN_TAPS = 9;   // 3x3 window, row by row
  localparam int NUM_CH   = 3;   // blue, green, red lanes

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [WIN_TAPS-1:0] win_t;

  // Horizontal and vertical Sobel kernels, row by row.
  localparam int KERN_H [WIN_TAPS] = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
  localparam int KERN_V [WIN_TAPS] = '{ 1, 2, 1,  0, 0, 0, -1, -2, -1};

  // Load strobes for the merge pipeline stages.
  typedef struct packed {
    logic load_sum;
    logic load_out;
  } pipe_ctl_t;

endpackage

// ===== design/sobel_rgb_gray_edge_core.sv =====
// Top level of the 3x3 Sobel gray edge core.
// Depends on sob_pkg, sob_lane, sob_merge and assert_macros.svh.
//
// Usage:
//   Input stream (s_axis_*): one transaction carries a full 3x3 window of
//   packed RGB pixels (red high, blue low). Output stream (m_axis_*): one
//   transaction per window, the gray edge strength copied into red, green
//   and blue.
//   Stages: three register stages hold the lane strengths, the channel
//   sum and the divided, clamped result, in that order.
//   Throughput: one window per cycle while the receiver takes results; the
//   three colour lanes run side by side and the merge stage is pipelined.
//   Stall: each stage holds its data while the stage after it is full and
//   blocked, so a waiting result does not stop earlier stages from filling;
//   up to three windows are in flight before s_axis_tready_o drops.
//   Reset: clears all stage valid flags; nothing is emitted until new input.
`include "assert_macros.svh"

module sobel_rgb_gray_edge_core #(
  parameter int COLOUR_BITS = 10  // bits per colour channel, 4..16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // fields from bit 0 up: pix_r0c0, pix_r0c1, pix_r0c2, pix_r1c0, pix_r1c1,
  // pix_r1c2, pix_r2c0, pix_r2c1, pix_r2c2 (30 bits each), 2 zero pad bits
  input  logic [271:0] s_axis_tdata_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // fields from bit 0 up: edge_pixel (30 bits), 2 zero pad bits
  output logic [31:0]  m_axis_tdata_o,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i
);

  localparam int SB = COLOUR_BITS + 3;  // lane strength width

  sob_pkg::win_t      win;
  logic [sob_pkg::NUM_CH-1:0][SB-1:0] lane_str;
  logic [sob_pkg::NUM_CH-1:0][SB-1:0] lane_str_q;
  sob_pkg::pipe_ctl_t ctl;
  sob_pkg::pix_t      pix;

  // stage valid flags: 1 = lane strengths, 2 = channel sum, 3 = output
  logic v1_d, v1_q;
  logic v2_d, v2_q;
  logic v3_d, v3_q;
  logic rdy1, rdy2, rdy3;
  logic s_fire;

  assign win = s_axis_tdata_i[sob_pkg::WIN_TAPS*sob_pkg::PIX_W-1:0];

  // colour lanes: 0 = blue, 1 = green, 2 = red
  for (genvar g = 0; g < sob_pkg::NUM_CH; g++) begin : g_lane
    sob_lane #(
      .COLOUR_BITS(COLOUR_BITS),
      .CH         (g)
    ) u_lane (
      .win_i     (win),
      .strength_o(lane_str[g])
    );
  end

  // a stage can take new data when empty or when its contents move on
  assign rdy3 = !v3_q || m_axis_tready_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign s_fire       = s_axis_tvalid_i && rdy1;
  assign ctl.load_sum = v1_q && rdy2;
  assign ctl.load_out = v2_q && rdy3;

  assign v1_d = rdy1 ? s_axis_tvalid_i : v1_q;
  assign v2_d = rdy2 ? v1_q : v2_q;
  assign v3_d = rdy3 ? v2_q : v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      lane_str_q <= lane_str;
    end
  end

  sob_merge #(
    .COLOUR_BITS(COLOUR_BITS)
  ) u_merge (
    .clk_i     (clk_i),
    .ctl_i     (ctl),
    .strength_i(lane_str_q),
    .pix_o     (pix)
  );

  assign s_axis_tready_o = rdy1;
  assign m_axis_tvalid_o = v3_q;
  assign m_axis_tdata_o  = {2'b00, pix};

  // accepted window lands in the lane stage
  `SOB_ASSERT(a_fire_fills_s1, clk_i, rst_ni, s_fire |=> v1_q, "window lost at stage 1")
  // blocked lane stage keeps its window
  `SOB_ASSERT(a_s1_hold, clk_i, rst_ni, (v1_q && !rdy2) |=> (v1_q && $stable(lane_str_q)), "stage 1 dropped data under stall")
  // blocked sum stage keeps its window
  `SOB_ASSERT(a_s2_hold, clk_i, rst_ni, (v2_q && !rdy3) |=> v2_q, "stage 2 dropped data under stall")

endmodule

// ===== design/sob_lane.sv =====
// One colour lane: Sobel Gx/Gy over the window and |Gx| + |Gy|.
// Depends on sob_pkg (window type and kernels).
module sob_lane #(
  parameter int COLOUR_BITS = 10,
  parameter int CH          = 0
) (
  input  sob_pkg::win_t           win_i,
  output logic [COLOUR_BITS+2:0]  strength_o
);

  localparam int CB = COLOUR_BITS;
  localparam int PW = (3 * CB > sob_pkg::PIX_W) ? 3 * CB : sob_pkg::PIX_W;
  localparam int SW = CB + 3;  // signed sum, |G| <= 4 * max

  logic signed [SW-1:0] sx;
  logic signed [SW-1:0] sy;
  logic        [SW-1:0] ux;
  logic        [SW-1:0] uy;
  logic        [CB+1:0] ax;
  logic        [CB+1:0] ay;

  always_comb begin
    logic [PW-1:0]        ext;
    logic signed [SW-1:0] cs;
    sx = '0;
    sy = '0;
    for (int k = 0; k < sob_pkg::WIN_TAPS; k++) begin
      // channels past the field width read as zero
      ext = PW'(win_i[k]);
      cs  = $signed(SW'(ext[CH*CB +: CB]));
      sx  = sx + $signed(SW'(sob_pkg::KERN_H[k])) * cs;
      sy  = sy + $signed(SW'(sob_pkg::KERN_V[k])) * cs;
    end
  end

  assign ux = sx[SW-1] ? SW'(-sx) : SW'(sx);
  assign uy = sy[SW-1] ? SW'(-sy) : SW'(sy);
  assign ax = ux[CB+1:0];
  assign ay = uy[CB+1:0];

  assign strength_o = (CB+3)'(ax) + (CB+3)'(ay);

endmodule

// ===== design/sob_merge.sv =====
// Merge stage: adds the lane strengths, divides by 3, clamps, packs gray.
// Depends on sob_pkg (pipeline control struct, pixel type).
module sob_merge #(
  parameter int COLOUR_BITS = 10
) (
  input  logic                                   clk_i,
  input  sob_pkg::pipe_ctl_t                     ctl_i,
  input  logic [sob_pkg::NUM_CH-1:0][COLOUR_BITS+2:0] strength_i,
  output sob_pkg::pix_t                          pix_o
);

  localparam int CB   = COLOUR_BITS;
  localparam int TW   = CB + 5;                  // total <= 24 * max
  localparam int SH   = TW + 1;
  localparam logic [TW-1:0] RECIP3 = TW'((2 ** SH + 2) / 3);  // ceil(2^SH / 3)
  localparam logic [CB-1:0] CMAX   = {CB{1'b1}};

  logic [TW-1:0]   total_d, total_q;
  logic [2*TW-1:0] prod;
  logic [TW-2:0]   quot;
  logic [CB-1:0]   avg;
  logic [3*CB-1:0] rep;
  sob_pkg::pix_t   pix_d, pix_q;

  assign total_d = TW'(strength_i[0]) + TW'(strength_i[1]) + TW'(strength_i[2]);

  // exact floor(total / 3) for any TW-bit total
  assign prod = (2*TW)'(total_q) * (2*TW)'(RECIP3);
  assign quot = prod[SH +: TW-1];
  assign avg  = (quot > (TW-1)'(CMAX)) ? CMAX : quot[CB-1:0];
  assign rep  = {avg, avg, avg};
  assign pix_d = sob_pkg::PIX_W'(rep);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_sum) begin
      total_q <= total_d;
    end
    if (ctl_i.load_out) begin
      pix_q <= pix_d;
    end
  end

  assign pix_o = pix_q;

endmodule

// ===== tb/sv/tb_sobel_rgb_gray_edge_core.sv =====
// Self-checking testbench for sobel_rgb_gray_edge_core (3x3 Sobel gray edge).
// Depends on sob_pkg; drives random and corner windows, scores each output
// against an in-bench edge strength predictor.
module tb_sobel_rgb_gray_edge_core;

  localparam int CB          = 10;                 // bits per colour channel
  localparam longint CH_MAX  = (64'd1 << CB) - 1;  // saturation value
  localparam longint PIX_MSK = (64'd1 << sob_pkg::PIX_W) - 1;
  localparam int CYCLE_LIMIT = 200000;             // hard stop for a hung run
  localparam int TAIL_CYCLES = 8;                  // pipeline depth is three

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #10 clk_i = ~clk_i;

  // stream signals
  logic [271:0] s_axis_tdata_i = '0;  // pix_r0c0 .. pix_r2c2 (30 bits each), 2 pad
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [31:0]  m_axis_tdata_o;       // edge_pixel (30 bits), 2 pad
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;

  sobel_rgb_gray_edge_core #(.COLOUR_BITS(CB)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i)
  );

  sob_pkg::pix_t pending_gray[$];   // predicted gray pixels, oldest first
  int   fail_cnt = 0;
  int   cyc_cnt = 0;
  bit   gaps_on = 1'b1;    // both sides idle at random while set

  // Edge strength predictor: per channel |Gx| + |Gy|, channels summed,
  // divided by three (truncating), saturated, then copied into R, G and B.
  function automatic sob_pkg::pix_t sobel_gray_of(sob_pkg::win_t w);
    longint gx, gy, tap, total, gray;
    total = 0;
    for (int ch = 0; ch < sob_pkg::NUM_CH; ch++) begin
      gx = 0;
      gy = 0;
      for (int k = 0; k < sob_pkg::WIN_TAPS; k++) begin
        tap = (longint'(w[k]) >> (ch * CB)) & CH_MAX;
        gx += sob_pkg::KERN_H[k] * tap;
        gy += sob_pkg::KERN_V[k] * tap;
      end
      total += (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
    end
    gray = total / 3;
    if (gray > CH_MAX) gray = CH_MAX;
    return sob_pkg::pix_t'(((gray << (2 * CB)) | (gray << CB) | gray) & PIX_MSK);
  endfunction

  function automatic sob_pkg::pix_t rgb(int unsigned r, int unsigned g, int unsigned b);
    return sob_pkg::pix_t'((longint'(r) << (2 * CB)) | (longint'(g) << CB) | longint'(b));
  endfunction

  // window with one row (is_row) or one column set to p, the rest black
  function automatic sob_pkg::win_t stripe(bit is_row, int idx, sob_pkg::pix_t p);
    sob_pkg::win_t w;
    w = '0;
    for (int k = 0; k < sob_pkg::WIN_TAPS; k++)
      if ((is_row ? k / 3 : k % 3) == idx) w[k] = p;
    return w;
  endfunction

  // Random window: plain noise, a noisy step edge, dim values or a nearly
  // flat patch (the last two land below saturation).
  function automatic sob_pkg::win_t rand_window();
    sob_pkg::win_t w;
    sob_pkg::pix_t a, b, n;
    bit   vert;
    a    = sob_pkg::pix_t'($urandom());
    b    = sob_pkg::pix_t'($urandom());
    vert = $urandom_range(0, 1);
    case ($urandom_range(0, 3))
      0: for (int k = 0; k < sob_pkg::WIN_TAPS; k++) w[k] = sob_pkg::pix_t'($urandom());
      1: for (int k = 0; k < sob_pkg::WIN_TAPS; k++) begin
        n = rgb($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15));
        w[k] = (((vert ? k % 3 : k / 3) < 1 + $urandom_range(0, 1)) ? a : b) ^ n;
      end
      2: for (int k = 0; k < sob_pkg::WIN_TAPS; k++)
        w[k] = rgb($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7));
      default: for (int k = 0; k < sob_pkg::WIN_TAPS; k++)
        w[k] = a ^ rgb($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3));
    endcase
    return w;
  endfunction

  // Send one window; the prediction is queued on the accepting edge.
  task automatic send_window(sob_pkg::win_t w);
    int gap;
    gap = gaps_on ? $urandom_range(0, 3) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tdata_i  <= {2'b00, w};
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_gray.push_back(sobel_gray_of(w));
  endtask

  task automatic sender_idle();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
  endtask

  task automatic wait_drain();
    while (pending_gray.size() != 0) @(posedge clk_i);
  endtask

  // Corner windows: flat fields, full-swing steps in both directions,
  // saturation boundary and truncation of the divide.
  task automatic test_corner_windows();
    sob_pkg::win_t w;
    send_window('0);
    send_window({sob_pkg::WIN_TAPS{sob_pkg::pix_t'(PIX_MSK)}});  // flat white: zero
    send_window(stripe(0, 2, sob_pkg::pix_t'(PIX_MSK)));  // rising step, saturates
    send_window(stripe(0, 0, sob_pkg::pix_t'(PIX_MSK)));  // falling step, Gx < 0
    send_window(stripe(1, 0, sob_pkg::pix_t'(PIX_MSK)));  // Gy > 0
    send_window(stripe(1, 2, sob_pkg::pix_t'(PIX_MSK)));  // Gy < 0
    send_window(stripe(0, 2, rgb(0, 0, 767)));        // just under the max
    send_window(stripe(0, 2, rgb(0, 0, 768)));        // just over: clamps
    send_window(stripe(0, 2, rgb(511, 0, 0)));        // red alone
    w = '0; w[5] = rgb(0, 0, 1);                      // total 2, truncates to 0
    send_window(w);
    w = '0; w[5] = rgb(0, 0, 2);                      // total 4, gives 1
    send_window(w);
    w = '0; w[2] = rgb(0, 1023, 0);                   // corner tap feeds both sums
    send_window(w);
    w = '0; w[4] = sob_pkg::pix_t'(PIX_MSK);          // center has zero weight
    send_window(w);
    for (int k = 0; k < sob_pkg::WIN_TAPS; k++)
      w[k] = (k % 2) ? sob_pkg::pix_t'(PIX_MSK) : '0;
    send_window(w);                                   // checkerboard
    w = stripe(0, 2, rgb(1023, 0, 0)) | stripe(0, 0, rgb(0, 1023, 0))
      | stripe(1, 0, rgb(0, 0, 1023));                // each channel a different edge
    send_window(w);
    for (int k = 0; k < sob_pkg::WIN_TAPS; k++) w[k] = sob_pkg::pix_t'(PIX_MSK) >> k;
    send_window(w);
    sender_idle();
  endtask

  // Back-to-back windows with the receiver always ready: full throughput.
  task automatic test_full_rate();
    gaps_on = 1'b0;
    repeat (60) send_window(rand_window());
    sender_idle();
    wait_drain();
    gaps_on = 1'b1;
  endtask

  // Let the pipeline empty completely mid-stream, then restart.
  task automatic test_drain_pause();
    repeat (12) send_window(rand_window());
    sender_idle();
    wait_drain();
    repeat (12) send_window(rand_window());
    sender_idle();
  endtask

  // Bulk random traffic; idling switches on and off in stretches of 40.
  task automatic test_random_windows();
    for (int i = 0; i < 300; i++) begin
      gaps_on = ((i / 40) % 2) == 0;
      send_window(rand_window());
    end
    gaps_on = 1'b1;
    sender_idle();
  endtask

  // Receiver: random stall before each output transaction.
  initial begin
    int stall;
    forever begin
      stall = gaps_on ? $urandom_range(0, 3) : 0;
      repeat (stall) begin
        @(negedge clk_i);
        m_axis_tready_i <= 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  // Scoreboard: every output transaction against the oldest prediction,
  // pad bits included.
  always @(posedge clk_i) begin
    sob_pkg::pix_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_gray.size() == 0) begin
        if (fail_cnt < 10) $display("unexpected output transaction: %h", m_axis_tdata_o);
        fail_cnt++;
      end else begin
        want = pending_gray.pop_front();
        if (m_axis_tdata_o !== {2'b00, want}) begin
          if (fail_cnt < 10)
            $display("edge_pixel mismatch: expected %h, got %h", {2'b00, want},
                     m_axis_tdata_o);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_corner_windows();
    test_full_rate();
    test_drain_pause();
    test_random_windows();
    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0 && pending_gray.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
